// ===== src/assert_macros.svh =====
// -----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; compiled out with NO_ASSERTIONS.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/trpd_pkg.sv =====
// -----------------------------------------------------------------------------
// trpd_pkg
// Types and constants of the TGA run-length pixel decoder.
// -----------------------------------------------------------------------------
package trpd_pkg;

    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned TotalW  = 32;
    localparam int unsigned ValueW  = 32;
    localparam int unsigned CountW  = 8;
    localparam int unsigned AccumW  = 24;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_BYTES_PER_PIXEL = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_PIXEL_TOTAL     = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_COMPRESSED_MODE = 2'd2;

    // register reset values
    localparam logic [2:0]        RST_BYTES_PER_PIXEL = 3'd3;
    localparam logic [TotalW-1:0] RST_PIXEL_TOTAL     = 32'd1;
    localparam logic              RST_COMPRESSED_MODE = 1'b1;

    // packet header: top bit picks run versus raw
    localparam int unsigned HdrRunBit = 7;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_RAW    = 3'b010,
        PH_RUN    = 3'b100
    } t_phase;

    typedef struct packed {
        logic [TotalW-1:0] first_index;
        logic [ValueW-1:0] pixel_value;
        logic [CountW-1:0] repeat_count;
        logic              image_done;
        logic              clipped;
    } t_result;

endpackage

// ===== src/trpd_out_skid.sv =====
// -----------------------------------------------------------------------------
// trpd_out_skid
// Two-entry result buffer: output register plus one skid entry.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module trpd_out_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,      // only while o_full is low
    input  trpd_pkg::t_result i_push_data,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_ready,
    output trpd_pkg::t_result o_data
);
    import trpd_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    out_load;

    assign out_load = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_load) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= i_push;
            end else begin
                r_out_valid  <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (r_skid_valid) begin
                r_out  <= r_skid;
                r_skid <= i_push_data;
            end else begin
                r_out  <= i_push_data;
            end
        end else if (i_push) begin
            r_skid <= i_push_data;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `ASSERT_NXT(a_skid_drains_to_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `ASSERT_IMP(a_no_push_when_full, i_clk, i_rst_n, i_push, !r_skid_valid)

endmodule

// ===== src/tga_rle_pixel_decoder.sv =====
// -----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// Rebuilds TGA pixels from the image data byte stream, raw or run-length coded.
// -----------------------------------------------------------------------------
//  channel  | direction | data                                   | sideband
//  ---------+-----------+----------------------------------------+----------------------
//  s (in)   | slave     | tdata[7:0] data_byte                   | tuser frame_start
//  m (out)  | master    | tdata first_index/pixel_value/repeat   | tlast image_done,
//           |           |                                        | tuser clipped
//  cfg      | write     | index: 0 bpp, 1 pixel total, 2 mode    | ready tied high
//
//  One byte word per clock while the output skid entry is empty. Each accepted
//  byte is decoded in the cycle it is accepted; its result (if any) is
//  registered in the output register, or in the skid entry while the output stalls.
//  Reset (synchronous, active low) loads the register defaults and clears the
//  decoder state. No clearing pass.
//  A stalled output fills a one-entry skid; the input drops ready only while
//  that skid entry is occupied, so s_tready is a register output.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module tga_rle_pixel_decoder #(
    parameter int unsigned MAX_BYTES_PER_PIXEL = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // byte input
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [7:0]                i_s_tdata,   // [7:0] data_byte
    input  logic                      i_s_tuser,   // [0] frame_start
    // pixel output
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [71:0]               o_m_tdata,   // [31:0] first_index,
                                                   // [63:32] pixel_value,
                                                   // [71:64] repeat_count
    output logic                      o_m_tlast,   // image_done
    output logic                      o_m_tuser,   // [0] clipped
    // configuration writes
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [trpd_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [31:0]               i_cfg_data
);
    import trpd_pkg::*;

    localparam logic [2:0] MaxBpp = 3'(MAX_BYTES_PER_PIXEL);

    // configuration
    logic [2:0]        r_bpp;
    logic [TotalW-1:0] r_total;
    logic              r_comp;

    // decoder state
    t_phase            r_phase,   n_phase;
    logic [6:0]        r_rem,     n_rem;
    logic [1:0]        r_bp,      n_bp;
    logic [AccumW-1:0] r_accum,   n_accum;
    logic [TotalW-1:0] r_pos,     n_pos;

    // state seen by this byte (restart folded in)
    t_phase            c_phase;
    logic [6:0]        c_rem;
    logic [1:0]        c_bp;
    logic [AccumW-1:0] c_accum;
    logic [TotalW-1:0] c_pos;

    logic              s_acc;
    logic              skid_full;
    logic [2:0]        eff_bpp;
    logic              partial;
    logic [4:0]        shamt;
    logic [ValueW-1:0] byte_shifted;
    logic [TotalW-1:0] left;
    logic [CountW-1:0] run_count;
    logic              emit;
    t_result           res;
    t_result           out_res;
    logic              out_valid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp   <= RST_BYTES_PER_PIXEL;
            r_total <= RST_PIXEL_TOTAL;
            r_comp  <= RST_COMPRESSED_MODE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BYTES_PER_PIXEL: r_bpp   <= i_cfg_data[2:0];
                CFG_PIXEL_TOTAL:     r_total <= i_cfg_data;
                CFG_COMPRESSED_MODE: r_comp  <= i_cfg_data[0];
                default:             ;
            endcase
        end
    end

    assign o_s_tready = !skid_full;
    assign s_acc      = i_s_tvalid && o_s_tready;

    // frame_start restarts before the byte is looked at
    assign c_phase = i_s_tuser ? PH_HEADER : r_phase;
    assign c_rem   = i_s_tuser ? 7'd0 : r_rem;
    assign c_bp    = i_s_tuser ? 2'd0 : r_bp;
    assign c_accum = i_s_tuser ? '0 : r_accum;
    assign c_pos   = i_s_tuser ? '0 : r_pos;

    // out-of-range pixel sizes clamp to 1 .. MAX_BYTES_PER_PIXEL
    always_comb begin
        priority if (r_bpp == 3'd0) begin
            eff_bpp = 3'd1;
        end else if (r_bpp > MaxBpp) begin
            eff_bpp = MaxBpp;
        end else begin
            eff_bpp = r_bpp;
        end
    end

    assign partial      = (({1'b0, c_bp} + 3'd1) < eff_bpp);
    assign shamt        = {c_bp, 3'b000};
    assign byte_shifted = {24'd0, i_s_tdata} << shamt;
    assign left         = r_total - c_pos;
    assign run_count    = {1'b0, c_rem} + 8'd1;

    always_comb begin
        n_phase = c_phase;
        n_rem   = c_rem;
        n_bp    = c_bp;
        n_accum = c_accum;
        n_pos   = c_pos;
        emit    = 1'b0;
        res.first_index  = c_pos;
        res.pixel_value  = {8'd0, c_accum} | byte_shifted;
        res.repeat_count = 8'd1;
        res.image_done   = 1'b0;
        res.clipped      = 1'b0;

        priority if (c_pos >= r_total) begin
            // image complete: byte dropped
        end else if (r_comp && (c_phase == PH_HEADER)) begin
            n_phase = i_s_tdata[HdrRunBit] ? PH_RUN : PH_RAW;
            n_rem   = i_s_tdata[6:0];
            n_bp    = 2'd0;
            n_accum = '0;
        end else if (partial) begin
            n_accum = c_accum | byte_shifted[AccumW-1:0];
            n_bp    = c_bp + 2'd1;
        end else begin
            emit    = 1'b1;
            n_bp    = 2'd0;
            n_accum = '0;
            if (r_comp && (c_phase == PH_RUN)) begin
                // run longer than what is left gets cut at the total
                if ({24'd0, run_count} > left) begin
                    res.repeat_count = left[CountW-1:0];
                    res.clipped      = 1'b1;
                end else begin
                    res.repeat_count = run_count;
                end
                n_phase = PH_HEADER;
                n_rem   = 7'd0;
            end else if (r_comp) begin
                res.clipped = (left == 32'd1) && (c_rem != 7'd0);
                if (c_rem == 7'd0) begin
                    n_phase = PH_HEADER;
                end else begin
                    n_rem = c_rem - 7'd1;
                end
            end
            // count never passes what is left, so done is an equality
            res.image_done = ({24'd0, res.repeat_count} == left);
            n_pos = c_pos + {24'd0, res.repeat_count};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_rem   <= 7'd0;
            r_bp    <= 2'd0;
            r_accum <= '0;
            r_pos   <= '0;
        end else if (s_acc) begin
            r_phase <= n_phase;
            r_rem   <= n_rem;
            r_bp    <= n_bp;
            r_accum <= n_accum;
            r_pos   <= n_pos;
        end
    end

    trpd_out_skid u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (s_acc && emit),
        .i_push_data (res),
        .o_full      (skid_full),
        .o_valid     (out_valid),
        .i_ready     (i_m_tready),
        .o_data      (out_res)
    );

    assign o_m_tvalid = out_valid;
    assign o_m_tdata  = {out_res.repeat_count, out_res.pixel_value, out_res.first_index};
    assign o_m_tlast  = out_res.image_done;
    assign o_m_tuser  = out_res.clipped;

    // a clipped packet always ends the image
    `ASSERT_IMP(a_clip_ends_image, i_clk, i_rst_n, o_m_tvalid && o_m_tuser, o_m_tlast)
    `ASSERT_IMP(a_count_nonzero, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[71:64] != 8'd0)
    // a decoded byte never moves the position past the total
    `ASSERT_IMP(a_pos_bounded, i_clk, i_rst_n, s_acc && emit, n_pos <= r_total)

endmodule

// ===== dv/tga_rle_pixel_checker.sv =====
// -----------------------------------------------------------------------------
// tga_rle_pixel_checker
// Watches the byte, pixel and register channels of the TGA run-length pixel
// decoder, predicts every pixel word and compares it with what comes out.
// -----------------------------------------------------------------------------
module tga_rle_pixel_checker #(
    parameter int unsigned MAX_BYTES_PER_PIXEL = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    input  logic                         i_s_tready,
    input  logic [7:0]                   i_s_tdata,
    input  logic                         i_s_tuser,
    input  logic                         i_m_tvalid,
    input  logic                         i_m_tready,
    input  logic [71:0]                  i_m_tdata,
    input  logic                         i_m_tlast,
    input  logic                         i_m_tuser,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_ready,
    input  logic [trpd_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [31:0]                  i_cfg_data,
    output int                           o_mismatches,
    output int                           o_pending
);
    import trpd_pkg::*;

    localparam int MaxReports = 10;

    // register copies
    logic [2:0]        bpp_reg;
    logic [TotalW-1:0] total_reg;
    logic              rle_on;

    // decode state
    t_phase            phase;
    logic [7:0]        pkt_left;
    logic [1:0]        byte_pos;
    logic [AccumW-1:0] accum;
    logic [TotalW-1:0] pix_pos;

    t_result due_pixels[$];
    int      mismatches;

    task automatic restart_image();
        phase    = PH_HEADER;
        pkt_left = '0;
        byte_pos = '0;
        accum    = '0;
        pix_pos  = '0;
    endtask

    // one accepted byte; pushes the pixel word it completes, if any
    task automatic decode_byte(input logic [7:0] b, input logic fs);
        t_result     px;
        logic [31:0] count;
        logic [31:0] left;
        logic        clip;
        int unsigned nb;
        nb = (bpp_reg == 0) ? 1 :
             (bpp_reg > MAX_BYTES_PER_PIXEL) ? MAX_BYTES_PER_PIXEL : bpp_reg;
        if (fs) restart_image();
        if (pix_pos >= total_reg) return;
        if (rle_on && phase == PH_HEADER) begin
            phase    = b[HdrRunBit] ? PH_RUN : PH_RAW;
            pkt_left = {1'b0, b[6:0]};
            byte_pos = '0;
            accum    = '0;
            return;
        end
        if (32'(byte_pos) + 32'd1 < nb) begin
            accum    = accum | (AccumW'(b) << (8 * byte_pos));
            byte_pos = byte_pos + 2'd1;
            return;
        end
        px.pixel_value = {8'h00, accum} | (32'(b) << (8 * byte_pos));
        byte_pos = '0;
        accum    = '0;
        left     = total_reg - pix_pos;
        count    = 32'd1;
        clip     = 1'b0;
        if (rle_on) begin
            if (phase == PH_RUN) begin
                count = 32'(pkt_left) + 32'd1;
                if (count > left) begin
                    count = left;
                    clip  = 1'b1;
                end
                phase    = PH_HEADER;
                pkt_left = '0;
            end else begin
                // raw packet: the pixel hitting the total cuts what is left
                if (left == 32'd1 && pkt_left != 0) clip = 1'b1;
                if (pkt_left == 0) phase = PH_HEADER;
                else pkt_left = pkt_left - 8'd1;
            end
        end
        px.first_index  = pix_pos;
        px.repeat_count = count[7:0];
        pix_pos         = pix_pos + count;
        px.image_done   = (pix_pos >= total_reg);
        px.clipped      = clip;
        due_pixels.push_back(px);
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            bpp_reg   = RST_BYTES_PER_PIXEL;
            total_reg = RST_PIXEL_TOTAL;
            rle_on    = RST_COMPRESSED_MODE;
            restart_image();
            due_pixels.delete();
            mismatches = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_BYTES_PER_PIXEL: bpp_reg   = i_cfg_data[2:0];
                    CFG_PIXEL_TOTAL:     total_reg = i_cfg_data;
                    CFG_COMPRESSED_MODE: rle_on    = i_cfg_data[0];
                    default: ;
                endcase
            end
            // a word leaving now belongs to an earlier byte, so pop before push
            if (i_m_tvalid && i_m_tready) begin
                got.first_index  = i_m_tdata[31:0];
                got.pixel_value  = i_m_tdata[63:32];
                got.repeat_count = i_m_tdata[71:64];
                got.image_done   = i_m_tlast;
                got.clipped      = i_m_tuser;
                if (due_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MaxReports)
                        $display("%0t: unexpected pixel word: index %0d value %h count %0d",
                                 $time, got.first_index, got.pixel_value, got.repeat_count);
                end else begin
                    want = due_pixels.pop_front();
                    if (got.first_index !== want.first_index ||
                        got.pixel_value !== want.pixel_value ||
                        got.repeat_count !== want.repeat_count ||
                        got.image_done !== want.image_done ||
                        got.clipped !== want.clipped) begin
                        mismatches++;
                        if (mismatches <= MaxReports)
                            $display({"%0t: pixel mismatch: index exp %0d got %0d, ",
                                      "value exp %h got %h, count exp %0d got %0d, ",
                                      "done exp %b got %b, clipped exp %b got %b"},
                                     $time, want.first_index, got.first_index,
                                     want.pixel_value, got.pixel_value,
                                     want.repeat_count, got.repeat_count,
                                     want.image_done, got.image_done,
                                     want.clipped, got.clipped);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) decode_byte(i_s_tdata, i_s_tuser);
        end
        o_mismatches <= mismatches;
        o_pending    <= due_pixels.size();
    end

endmodule

// ===== dv/tga_rle_pixel_decoder_test.sv =====
// -----------------------------------------------------------------------------
// tga_rle_pixel_decoder_test
// Drives image byte streams and register settings into the decoder; a checker
// beside it predicts every pixel word. Directed corner cases come first, then
// random packet streams with random stalls on both sides.
// -----------------------------------------------------------------------------
module tga_rle_pixel_decoder_test;
    import trpd_pkg::*;

    localparam int unsigned MaxBpp      = 4;
    localparam int          IdleLimit   = 1000;   // cycles with no word moving
    localparam int          RandomBytes = 650;
    localparam logic [31:0] TOTAL_MAX   = 32'd4294836225;

    // index outside the register map: must not change anything
    localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

    // which registers a format update writes
    localparam logic [2:0] WR_BPP   = 3'b001;
    localparam logic [2:0] WR_TOTAL = 3'b010;
    localparam logic [2:0] WR_MODE  = 3'b100;
    localparam logic [2:0] WR_ALL   = 3'b111;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;
    logic               s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [71:0]        m_tdata;
    logic               m_tlast;
    logic               m_tuser;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CfgIdxW-1:0] cfg_index;
    logic [31:0]        cfg_data;

    int mismatches;
    int pending;        // pixel words predicted but not yet seen
    int idle_cycles = 0;
    int bytes_sent;
    bit new_frame;      // next byte carries frame_start

    // what the registers hold now, as the stimulus side sees them
    logic [2:0]  cur_bpp;
    logic        cur_mode;

    tga_rle_pixel_decoder #(
        .MAX_BYTES_PER_PIXEL(MaxBpp)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .o_m_tuser  (m_tuser),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    tga_rle_pixel_checker #(
        .MAX_BYTES_PER_PIXEL(MaxBpp)
    ) pixel_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tlast   (m_tlast),
        .i_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_mismatches(mismatches),
        .o_pending   (pending)
    );

    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Stall length before the next word. Every fourth stretch of 40 words
    // runs with no gaps at all, so back-to-back traffic is covered too.
    function automatic int pause_len(int n);
        return ((n / 40) % 4 == 3) ? 0 : int'($urandom_range(0, 12));
    endfunction

    // Watchdog: a correct run never sits this long without moving a word.
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IdleLimit) begin
            $display("[tga_rle_pixel_decoder] ERROR");
            $finish;
        end
    end

    // Pixel sink: random backpressure per word.
    initial begin : pixel_sink
        int gap;
        int taken;
        taken = 0;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            gap = pause_len(taken);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
            taken++;
        end
    end

    // One byte word; valid stays up into the next word when no gap is drawn.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pause_len(bytes_sent);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= new_frame;
        new_frame = 1'b0;
        do @(posedge clk); while (!(s_tvalid && s_tready));
        bytes_sent++;
    endtask

    // run packet: header then one pixel
    task automatic send_run(input int len, input int nb);
        send_byte(8'(127 + len));
        repeat (nb) send_byte(8'($urandom));
    endtask

    // raw packet: header then n full pixels
    task automatic send_raw(input int n, input int nb);
        send_byte(8'(n - 1));
        repeat (n * nb) send_byte(8'($urandom));
    endtask

    // Stop sending and wait until every predicted word has been seen at the
    // output, so registers change only when idle.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (3) @(posedge clk);
    endtask

    // valid is left high; the caller lowers it after the last write
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
    endtask

    // Upper size and mode data bits are random: the decoder must use only the field bits.
    task automatic set_format(input logic [2:0] mask, input logic [2:0] bpp,
                              input logic [31:0] total, input logic mode);
        if ((mask & WR_BPP) != 0) begin
            write_reg(CFG_BYTES_PER_PIXEL, (32'($urandom) & ~32'h7) | 32'(bpp));
            cur_bpp = bpp;
        end
        if ((mask & WR_TOTAL) != 0)
            write_reg(CFG_PIXEL_TOTAL, total);
        if ((mask & WR_MODE) != 0) begin
            write_reg(CFG_COMPRESSED_MODE, (32'($urandom) & ~32'h1) | 32'(mode));
            cur_mode = mode;
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int k;
        int nb;
        int pkts;
        logic [2:0]  bpp;
        logic [31:0] total;
        logic        mode;
        bit          carry_on;

        bytes_sent  = 0;
        new_frame   = 1'b0;
        cur_bpp     = RST_BYTES_PER_PIXEL;
        cur_mode    = RST_COMPRESSED_MODE;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed ---------------------------------------------------

        // reset format (3 bytes, one pixel, compressed): one raw pixel ends
        // the image, the byte after it must be ignored
        new_frame = 1'b1;
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h5A);
        send_byte(8'hFF);
        settle();

        // write to an unmapped index, then a run of 4 and a run of 128 that
        // gets cut to the one pixel left
        write_reg(CFG_UNUSED, $urandom);
        set_format(WR_ALL, 3'd1, 32'd5, 1'b1);
        new_frame = 1'b1;
        send_byte(8'h83);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h00);
        settle();

        // raw of 2, then raw of 128 clipped on the image's last pixel
        set_format(WR_ALL, 3'd2, 32'd3, 1'b1);
        new_frame = 1'b1;
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'h01);
        send_byte(8'hFE);
        send_byte(8'h7F);
        send_byte(8'h00);
        send_byte(8'hFF);
        settle();

        // zero pixel total: everything ignored
        set_format(WR_ALL, 3'd0, 32'd0, 1'b0);
        new_frame = 1'b1;
        send_byte(8'hAA);
        settle();

        // bytes per pixel 0 behaves as 1, uncompressed
        set_format(WR_TOTAL, 3'd0, 32'd2, 1'b0);
        new_frame = 1'b1;
        send_byte(8'h12);
        send_byte(8'h34);
        settle();

        // bytes per pixel 7 behaves as 4, total of 65535 squared
        set_format(WR_ALL, 3'd7, TOTAL_MAX, 1'b0);
        new_frame = 1'b1;
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h55);
        send_byte(8'hAA);
        // three bytes into a pixel, then shrink the pixel size: the next
        // byte completes it at four bytes
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'h03);
        settle();
        set_format(WR_BPP, 3'd2, 32'd0, 1'b0);
        send_byte(8'hC4);
        settle();

        // --- random -----------------------------------------------------
        // Each phase picks a format, mostly starts a new image and sends
        // well-formed packets with random content; stray bytes and restarts
        // in the middle of an image are mixed in. Some phases keep the image
        // going and change part or all of the format.
        k = bytes_sent + RandomBytes;
        while (bytes_sent < k) begin
            int sel;
            sel = $urandom_range(0, 15);
            bpp = (sel == 0) ? 3'd0 : (sel == 1) ? 3'($urandom_range(5, 7))
                                                 : 3'($urandom_range(1, 4));
            mode = ($urandom_range(0, 3) != 0);
            sel = $urandom_range(0, 19);
            total = (sel == 0) ? 32'd0 : (sel == 1) ? 32'($urandom) :
                    (sel == 2) ? TOTAL_MAX : 32'($urandom_range(1, 24));
            carry_on = ($urandom_range(0, 5) == 0);

            settle();
            set_format(carry_on ? 3'($urandom_range(1, 7)) : WR_ALL, bpp, total, mode);
            new_frame = !carry_on;

            nb = (cur_bpp == 0) ? 1 : (cur_bpp > MaxBpp) ? MaxBpp : int'(cur_bpp);
            pkts = $urandom_range(1, 8);
            repeat (pkts) begin
                if (cur_mode) begin
                    if ($urandom_range(0, 1) == 0)
                        send_run(($urandom_range(0, 7) == 0) ? $urandom_range(1, 128)
                                                             : $urandom_range(1, 4), nb);
                    else
                        send_raw(($urandom_range(0, 31) == 0) ? $urandom_range(1, 128)
                                                              : $urandom_range(1, 5), nb);
                end else begin
                    repeat ($urandom_range(1, 3) * nb) send_byte(8'($urandom));
                end
                sel = $urandom_range(0, 19);
                if (sel == 0) begin
                    // stray byte: knocks the packet framing out of step
                    send_byte(8'($urandom));
                end else if (sel == 1) begin
                    // restart in the middle of an image
                    new_frame = 1'b1;
                    send_byte(8'($urandom));
                end
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("[tga_rle_pixel_decoder] OK");
        else
            $display("[tga_rle_pixel_decoder] ERROR");
        $finish;
    end

endmodule
